>>> rtl/htfd_pkg.sv
// Shared types, constants and the CRC step for the humidity / temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0]  CRC_POLY     = 8'h31;
   localparam logic [7:0]  CRC_INIT     = 8'hFF;
   localparam logic [2:0]  POS_IDLE     = 3'd0;
   localparam logic [2:0]  POS_FIRST    = 3'd1;
   localparam logic [2:0]  POS_LAST     = 3'd5;
   localparam logic [13:0] HUM_SCALE    = 14'd10000;
   localparam logic [14:0] TEMP_SCALE   = 15'd20000;
   localparam logic [14:0] TEMP_OFFSET  = 15'd5000;
   localparam logic [19:0] TEMP_MIN_RST = 20'd52429;
   localparam logic [19:0] TEMP_MAX_RST = 20'd707788;

   typedef enum logic [1:0] {
      CSR_CRC_ENFORCE  = 2'd0,
      CSR_TEMP_RAW_MIN = 2'd1,
      CSR_TEMP_RAW_MAX = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [7:0]  status_byte;
      logic [19:0] humidity_raw;
      logic [19:0] temperature_raw;
      logic        crc_match;
   } frame_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/htfd_frame_asm.sv
// Frame assembler: byte position, running CRC and storage of the first five frame bytes.
module htfd_frame_asm (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          frame_byte,
   input  logic                frame_start,
   output logic                frame_done,
   output htfd_pkg::frame_type frame
);
   import htfd_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] store_ff [5];

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      frame_done = 1'b0;
      if (accept) begin
         if (frame_start) begin
            crc_in = crc_step(CRC_INIT, frame_byte);
            pos_in = POS_FIRST;
         end else if (pos_ff == POS_IDLE || pos_ff > POS_LAST) begin
            pos_in = POS_IDLE;
         end else if (pos_ff < POS_LAST) begin
            crc_in = crc_step(crc_ff, frame_byte);
            pos_in = pos_ff + 3'd1;
         end else begin
            frame_done = 1'b1;
            crc_in     = CRC_INIT;
            pos_in     = POS_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // A start byte always lands in slot zero; later bytes land at their position.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (frame_start) begin
            store_ff[0] <= frame_byte;
         end else if (pos_ff != POS_IDLE && pos_ff < POS_LAST) begin
            store_ff[pos_ff] <= frame_byte;
         end
      end
   end

   assign frame.status_byte     = store_ff[0];
   assign frame.humidity_raw    = {store_ff[1], store_ff[2], store_ff[3][7:4]};
   assign frame.temperature_raw = {store_ff[3][3:0], store_ff[4], frame_byte};
   assign frame.crc_match       = (crc_ff == frame_byte);

endmodule

>>> rtl/humidity_temp_frame_decoder.sv
// Top level of the humidity / temperature frame decoder: register file, checks and scaling.
//
//   channel   | direction | handshake            | content
//   req       | in        | req_valid/req_ready  | one frame byte and its start mark
//   rsp       | out       | rsp_valid/rsp_ready  | one decoded reading per complete frame
//   csr (APB) | in/out    | psel/penable/pready  | crc_enforce, temp_raw_min, temp_raw_max
//
// One byte is taken per cycle while req_ready is high. A sixth byte is registered with its
// raw values and checks, then scaled by two constant multipliers into the output register.
// The output register and the check stage both move while the result side takes data, so a
// stalled result stops new requests only once both stages hold a reading.
// Reset is synchronous, clears the byte position, CRC and stage valids and resets the CSRs.
module humidity_temp_frame_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_frame_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_status_byte,
   output logic [19:0]        rsp_humidity_raw,
   output logic [19:0]        rsp_temperature_raw,
   output logic [13:0]        rsp_humidity_centi,
   output logic signed [14:0] rsp_temperature_centi,
   output logic               rsp_crc_match,
   output logic               rsp_range_ok,
   output logic               rsp_reading_valid,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import htfd_pkg::*;

   logic        crc_enforce_ff;
   logic [19:0] temp_min_ff;
   logic [19:0] temp_max_ff;
   csr_idx_type csr_idx;
   logic        csr_write;

   logic        req_accept;
   logic        frame_done;
   frame_type   frame;
   logic        range_ok;

   logic        s1_valid_ff, s1_valid_in;
   frame_type   s1_frame_ff;
   logic        s1_range_ok_ff;
   logic        s1_reading_valid_ff;
   logic        out_free;
   logic        s1_move;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_status_ff;
   logic [19:0] rsp_hum_raw_ff;
   logic [19:0] rsp_temp_raw_ff;
   logic [13:0] rsp_hum_centi_ff;
   logic [14:0] rsp_temp_centi_ff;
   logic        rsp_crc_match_ff;
   logic        rsp_range_ok_ff;
   logic        rsp_reading_valid_ff;

   logic [33:0] hum_prod;
   logic [34:0] temp_prod;

   // Register file
   assign pready    = 1'b1;
   assign csr_idx   = csr_idx_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enforce_ff <= 1'b0;
         temp_min_ff    <= TEMP_MIN_RST;
         temp_max_ff    <= TEMP_MAX_RST;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_CRC_ENFORCE:  crc_enforce_ff <= pwdata[0];
            CSR_TEMP_RAW_MIN: temp_min_ff    <= pwdata[19:0];
            CSR_TEMP_RAW_MAX: temp_max_ff    <= pwdata[19:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_CRC_ENFORCE:  prdata = {31'd0, crc_enforce_ff};
         CSR_TEMP_RAW_MIN: prdata = {12'd0, temp_min_ff};
         CSR_TEMP_RAW_MAX: prdata = {12'd0, temp_max_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // Handshake and stage control
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_move     = s1_valid_ff && out_free;
   assign req_ready   = !s1_valid_ff || out_free;
   assign req_accept  = req_valid && req_ready;
   assign s1_valid_in = frame_done || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   htfd_frame_asm u_frame_asm (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .frame_byte  (req_frame_byte),
      .frame_start (req_frame_start),
      .frame_done  (frame_done),
      .frame       (frame)
   );

   assign range_ok = (frame.temperature_raw >= temp_min_ff) &&
                     (frame.temperature_raw <= temp_max_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         s1_frame_ff         <= frame;
         s1_range_ok_ff      <= range_ok;
         s1_reading_valid_ff <= range_ok && (frame.crc_match || !crc_enforce_ff);
      end
   end

   // Scaling: floor(raw * k / 2^20) is the top bits of the product.
   assign hum_prod  = 34'(s1_frame_ff.humidity_raw) * 34'(HUM_SCALE);
   assign temp_prod = 35'(s1_frame_ff.temperature_raw) * 35'(TEMP_SCALE);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff        <= s1_frame_ff.status_byte;
         rsp_hum_raw_ff       <= s1_frame_ff.humidity_raw;
         rsp_temp_raw_ff      <= s1_frame_ff.temperature_raw;
         rsp_hum_centi_ff     <= hum_prod[33:20];
         rsp_temp_centi_ff    <= temp_prod[34:20] - TEMP_OFFSET;
         rsp_crc_match_ff     <= s1_frame_ff.crc_match;
         rsp_range_ok_ff      <= s1_range_ok_ff;
         rsp_reading_valid_ff <= s1_reading_valid_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status_byte       = rsp_status_ff;
   assign rsp_humidity_raw      = rsp_hum_raw_ff;
   assign rsp_temperature_raw   = rsp_temp_raw_ff;
   assign rsp_humidity_centi    = rsp_hum_centi_ff;
   assign rsp_temperature_centi = $signed(rsp_temp_centi_ff);
   assign rsp_crc_match         = rsp_crc_match_ff;
   assign rsp_range_ok          = rsp_range_ok_ff;
   assign rsp_reading_valid     = rsp_reading_valid_ff;

   a_valid_needs_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_reading_valid_ff |-> rsp_range_ok_ff)
      else $error("reading flagged valid without a passing range check");

   a_stage_advances: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_free |=> rsp_valid_ff)
      else $error("checked reading did not reach the output register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_accept && s1_valid_ff |-> out_free)
      else $error("request taken while the check stage was blocked");

   a_humidity_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_hum_centi_ff <= 14'd9999)
      else $error("humidity result out of range");

   a_temp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $signed(rsp_temp_centi_ff) >= -15'sd5000)
      else $error("temperature result below the lower bound");

endmodule

>>> tb/humidity_temp_frame_decoder_checker.sv
// Checker for the frame decoder: predicts each reading from the observed traffic and compares.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_frame_byte,
   input  logic               req_frame_start,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_status_byte,
   input  logic [19:0]        rsp_humidity_raw,
   input  logic [19:0]        rsp_temperature_raw,
   input  logic [13:0]        rsp_humidity_centi,
   input  logic signed [14:0] rsp_temperature_centi,
   input  logic               rsp_crc_match,
   input  logic               rsp_range_ok,
   input  logic               rsp_reading_valid,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fail_count,
   output int                 readings_pending
);
   import htfd_pkg::*;

   typedef struct packed {
      logic [7:0]         status;
      logic [19:0]        hum_raw;
      logic [19:0]        temp_raw;
      logic [13:0]        hum_centi;
      logic signed [14:0] temp_centi;
      logic               crc_ok;
      logic               in_range;
      logic               usable;
   } reading_type;

   // Own copy of the decoder state and its registers.
   logic [2:0]  frame_pos;
   logic [7:0]  crc_run;
   logic [7:0]  frame_bytes [0:4];
   logic        enforce_crc;
   logic [19:0] temp_floor;
   logic [19:0] temp_ceiling;
   reading_type expected_q [$];
   int          errors = 0;

   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] v;
      v = acc ^ data;
      repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      return v;
   endfunction

   task automatic apply_csr(input logic [3:0] addr, input logic [31:0] data);
      case (addr[3:2])
         CSR_CRC_ENFORCE:  enforce_crc = data[0];
         CSR_TEMP_RAW_MIN: temp_floor = data[19:0];
         CSR_TEMP_RAW_MAX: temp_ceiling = data[19:0];
         default: ;
      endcase
   endtask

   task automatic take_byte(input logic [7:0] b, input logic s);
      reading_type r;
      logic [19:0] hum;
      logic [19:0] tmp;
      logic [63:0] hum_prod;
      logic [63:0] tmp_prod;
      if (s) begin
         frame_bytes[0] = b;
         crc_run = crc8_next(CRC_INIT, b);
         frame_pos = POS_FIRST;
      end else if (frame_pos == POS_IDLE || frame_pos > POS_LAST) begin
         frame_pos = POS_IDLE;
      end else if (frame_pos < POS_LAST) begin
         frame_bytes[frame_pos] = b;
         crc_run = crc8_next(crc_run, b);
         frame_pos = frame_pos + 3'd1;
      end else begin
         // The sixth byte is both the low temperature byte and the CRC byte.
         hum = {frame_bytes[1], frame_bytes[2], frame_bytes[3][7:4]};
         tmp = {frame_bytes[3][3:0], frame_bytes[4], b};
         hum_prod = {44'd0, hum} * 64'd10000;
         tmp_prod = {44'd0, tmp} * 64'd20000;
         r.status     = frame_bytes[0];
         r.hum_raw    = hum;
         r.temp_raw   = tmp;
         r.hum_centi  = hum_prod[33:20];
         r.temp_centi = tmp_prod[34:20] - 15'd5000;
         r.crc_ok     = (crc_run == b);
         r.in_range   = (tmp >= temp_floor) && (tmp <= temp_ceiling);
         r.usable     = r.in_range && (r.crc_ok || !enforce_crc);
         expected_q.push_back(r);
         frame_pos = POS_IDLE;
         crc_run = CRC_INIT;
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic match_reading();
      reading_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $error("reading with none expected: status_byte %0h", rsp_status_byte);
      end else begin
         want = expected_q.pop_front();
         check_field("status_byte", want.status, rsp_status_byte);
         check_field("humidity_raw", want.hum_raw, rsp_humidity_raw);
         check_field("temperature_raw", want.temp_raw, rsp_temperature_raw);
         check_field("humidity_centi", want.hum_centi, rsp_humidity_centi);
         check_field("temperature_centi", $signed(want.temp_centi), rsp_temperature_centi);
         check_field("crc_match", want.crc_ok, rsp_crc_match);
         check_field("range_ok", want.in_range, rsp_range_ok);
         check_field("reading_valid", want.usable, rsp_reading_valid);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_pos = POS_IDLE;
         crc_run = CRC_INIT;
         enforce_crc = 1'b0;
         temp_floor = TEMP_MIN_RST;
         temp_ceiling = TEMP_MAX_RST;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            apply_csr(paddr, pwdata);
         end
         if (rsp_valid && rsp_ready) begin
            match_reading();
         end
         if (req_valid && req_ready) begin
            take_byte(req_frame_byte, req_frame_start);
         end
      end
      readings_pending <= expected_q.size();
      fail_count <= errors;
   end

endmodule

>>> tb/humidity_temp_frame_decoder_tb.sv
// Top of the frame decoder testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;
   import htfd_pkg::*;

   localparam int PHASE_ITEMS   = 400;
   localparam int PHASES        = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 6;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_frame_byte;
   logic               req_frame_start;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_status_byte;
   logic [19:0]        rsp_humidity_raw;
   logic [19:0]        rsp_temperature_raw;
   logic [13:0]        rsp_humidity_centi;
   logic signed [14:0] rsp_temperature_centi;
   logic               rsp_crc_match;
   logic               rsp_range_ok;
   logic               rsp_reading_valid;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   int                 fail_count;
   int                 readings_pending;

   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   bit          sender_calm = 1'b0;
   bit          receiver_calm = 1'b0;
   bit          squeeze_req = 1'b0;
   logic [19:0] lim_lo = TEMP_MIN_RST;
   logic [19:0] lim_hi = TEMP_MAX_RST;

   humidity_temp_frame_decoder dut (.*);
   humidity_temp_frame_decoder_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one and now and then a long one.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] frame_crc(input logic [39:0] head);
      logic [7:0] acc;
      acc = CRC_INIT;
      for (int i = 0; i < 5; i++) begin
         acc = acc ^ head[39 - 8 * i -: 8];
         repeat (8) acc = acc[7] ? ({acc[6:0], 1'b0} ^ CRC_POLY) : {acc[6:0], 1'b0};
      end
      return acc;
   endfunction

   task automatic send_request(input logic [7:0] b, input logic s, input bit counted);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_byte <= b;
      req_frame_start <= s;
      do @(posedge clock); while (!req_ready);
      if (counted) bytes_sent++;
   endtask

   task automatic send_frame(input logic [47:0] f);
      for (int i = 0; i < 6; i++) begin
         send_request(f[47 - 8 * i -: 8], i == 0, 1'b1);
      end
   endtask

   // psel stays high between back-to-back writes so that it is lowered once, after the last.
   task automatic write_csr(input csr_idx_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic configure(input logic enf, input logic [19:0] lo, input logic [19:0] hi);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(CSR_CRC_ENFORCE, {junk[31:1], enf});
      write_csr(CSR_TEMP_RAW_MIN, {junk[31:20], lo});
      write_csr(CSR_TEMP_RAW_MAX, {~junk[31:20], hi});
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      lim_lo = lo;
      lim_hi = hi;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (readings_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_frame();
      logic [47:0] f;
      logic [19:0] t;
      int          kind;
      int          cut;
      if ($urandom_range(0, 9) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 9) == 0) receiver_calm = !receiver_calm;
      f[47:16] = $urandom;
      f[15:0] = 16'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         f[7:0] = frame_crc(f[47:8]);
      end else if (kind < 75) begin
         // Temperatures on and just beside the configured limits, and the code extremes.
         case ($urandom_range(0, 5))
            0: t = lim_lo - 20'd1;
            1: t = lim_lo;
            2: t = lim_hi;
            3: t = lim_hi + 20'd1;
            4: t = '0;
            default: t = '1;
         endcase
         f[19:0] = t;
         if ($urandom_range(0, 1) == 1) begin
            f[39:20] = ($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'h00000;
         end
      end
      if (kind >= 95) begin
         // A broken frame: the next start mark drops it.
         cut = $urandom_range(1, 5);
         for (int i = 0; i < cut; i++) begin
            send_request(f[47 - 8 * i -: 8], i == 0, 1'b1);
         end
      end else if (kind >= 90) begin
         repeat ($urandom_range(1, 3)) send_request(8'($urandom), 1'b0, 1'b0);
         send_frame(f);
      end else begin
         send_frame(f);
      end
   endtask

   // The result side: random stalls, and one long hold-off once the stimulus asks for it.
   initial begin
      bit held_off;
      int stall;
      held_off = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_req && !held_off) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = pick_gap(receiver_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL humidity_temp_frame_decoder");
            $finish;
         end
      end
   end

   initial begin
      int          phase_start;
      logic        enf;
      logic [19:0] lo;
      logic [19:0] hi;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_frame_byte <= '0;
      req_frame_start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: a stray byte with no frame open, all-zero
      // and all-ones frames, a frame cut short by a new start, and the upper limit exactly.
      send_request(8'hA5, 1'b0, 1'b0);
      send_frame({40'h0, frame_crc(40'h0)});
      send_frame({48{1'b1}});
      send_request(8'($urandom), 1'b1, 1'b1);
      send_request(8'($urandom), 1'b0, 1'b1);
      send_frame({8'h00, 20'hFFFFF, TEMP_MAX_RST});

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin enf = 1'b1; lo = 20'h00000; hi = 20'hFFFFF; end
            1: begin enf = 1'b0; lo = 20'hFFFFF; hi = 20'h00000; end
            2: begin
               enf = 1'b1;
               lo = 20'($urandom_range(0, 20'h7FFFF));
               hi = lo + 20'($urandom_range(0, 300000));
            end
            3: begin enf = 1'b0; lo = 20'($urandom_range(0, 20'hFFFFF)); hi = lo; end
            default: begin enf = 1'b1; lo = TEMP_MIN_RST; hi = TEMP_MAX_RST; end
         endcase
         configure(enf, lo, hi);
         if (phase == 2) squeeze_req = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_ITEMS) random_frame();
      end

      settle();
      if (fail_count == 0) begin
         $display("PASS humidity_temp_frame_decoder");
      end else begin
         $display("FAIL humidity_temp_frame_decoder");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/htfd_pkg.sv
rtl/htfd_frame_asm.sv
rtl/humidity_temp_frame_decoder.sv
tb/humidity_temp_frame_decoder_checker.sv
tb/humidity_temp_frame_decoder_tb.sv
